// ----- rtl/ppc_pkg.sv -----
// Package for the PowerPC subset executor: opcodes, sub-encodings, state and command types.
// Used by ppc_ctrl, ppc_dpath and the top level; depends on nothing.
package ppc_pkg;

   localparam int MEM_BYTES = 65536;
   localparam int ADDR_W = $clog2(MEM_BYTES);

   localparam logic [5:0] OP_OUT   = 6'd1;
   localparam logic [5:0] OP_CMPI  = 6'd11;
   localparam logic [5:0] OP_ADDI  = 6'd14;
   localparam logic [5:0] OP_BC    = 6'd16;
   localparam logic [5:0] OP_B     = 6'd18;
   localparam logic [5:0] OP_XL    = 6'd19;
   localparam logic [5:0] OP_RLWNM = 6'd21;
   localparam logic [5:0] OP_X     = 6'd31;
   localparam logic [5:0] OP_LWZ   = 6'd32;
   localparam logic [5:0] OP_STW   = 6'd36;
   localparam logic [5:0] OP_STWU  = 6'd37;
   localparam logic [5:0] OP_LMW   = 6'd46;
   localparam logic [5:0] OP_STMW  = 6'd47;

   localparam logic [8:0] X9_ADD  = 9'd266;
   localparam logic [8:0] X9_SUBF = 9'd40;
   localparam logic [9:0] X10_MFLR = 10'd339;
   localparam logic [9:0] X10_MTLR = 10'd467;
   localparam logic [9:0] X10_MR   = 10'd444;
   localparam logic [9:0] X10_CMP  = 10'd0;
   localparam logic [9:0] X10_SLW  = 10'd24;
   localparam logic [9:0] X10_BLR  = 10'd16;

   localparam logic [4:0] BO_NE = 5'd4;
   localparam logic [4:0] BO_GT = 5'd2;
   localparam logic [4:0] BO_LT = 5'd1;

   localparam logic [2:0] CR_LT = 3'd1;
   localparam logic [2:0] CR_GT = 3'd2;
   localparam logic [2:0] CR_EQ = 3'd4;

   localparam logic [0:0] CSR_STACK = 1'b0;
   localparam logic [0:0] CSR_ARG   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MEM, ST_MEMWB, ST_RESP
   } state_type;

   // Command from controller to datapath.
   typedef struct packed {
      logic load_instr;   // capture instruction, start register read
      logic exec;         // execute a register (non-memory) instruction
      logic mem_start;    // issue the next memory byte access
      logic mem_wb;       // complete that access
      logic finish;       // commit pc, load response register
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_mem;       // instruction needs memory accesses
      logic mem_last;     // current byte is the last one of the last word
   } stat_type;

endpackage

// ----- rtl/ppc_ctrl.sv -----
// Controller of the PowerPC subset executor: sequences read, execute, memory and response.
// Depends on ppc_pkg.
module ppc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ppc_pkg::stat_type stat,
   output ppc_pkg::cmd_type  cmd
);
   import ppc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  state_in = stat.is_mem ? ST_MEM : ST_RESP;
         ST_MEM:   state_in = ST_MEMWB;
         ST_MEMWB: state_in = stat.mem_last ? ST_RESP : ST_MEM;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_instr = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = ~stat.is_mem;
            cmd.finish = ~stat.is_mem;
         end
         ST_MEM:   cmd.mem_start = 1'b1;
         ST_MEMWB: begin
            cmd.mem_wb = 1'b1;
            cmd.finish = stat.mem_last;
         end
         ST_RESP:  rsp_valid = 1'b1;
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_resp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken while response pending");
   a_finish_once: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid) else $error("finish without response");
`endif
endmodule

// ----- rtl/ppc_dpath.sv -----
// Datapath of the PowerPC subset executor: register file, ALU, branch unit and byte memory.
// Depends on ppc_pkg; driven by ppc_ctrl commands.
module ppc_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  ppc_pkg::cmd_type          cmd,
   output ppc_pkg::stat_type         stat,
   input  logic [31:0]               req_instr,
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [31:0]               csr_data,
   output logic [15:0]               rsp_next_pc,
   output logic                      rsp_out_valid,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_halted
);
   import ppc_pkg::*;

   logic [31:0] gpr_ff [32];
   logic [2:0]  cr_ff [8];
   logic [31:0] lr_ff;
   logic [ADDR_W-1:0] pc_ff;
   logic [31:0] ir_ff;
   logic [31:0] rs_ff, ra_ff, rb_ff;
   logic [31:0] ea_ff;
   logic [4:0]  mreg_ff;
   logic [1:0]  mbyte_ff;
   logic [31:0] mword_ff;
   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  mrd_ff;
   logic [ADDR_W-1:0] npc_ff, npc_in;
   logic        halt_in;
   logic [15:0] rsp_pc_ff;
   logic        rsp_ov_ff, rsp_h_ff;
   logic [7:0]  rsp_ch_ff;

   logic [5:0] op;
   logic [4:0] rt, ra, rb, mb, me;
   logic [8:0] x9;
   logic [9:0] x10;
   logic [31:0] d, base, seq32, rot, m1, m2, mask, cmpb;
   logic [ADDR_W-1:0] seq;
   logic [2:0] crv, cmpres;
   logic taken, bo_ok, is_mem, wr_en;
   logic [4:0] wr_idx;
   logic [31:0] wr_val;
   logic lr_we;
   logic [31:0] lr_val;
   logic cr_we;

   assign op  = ir_ff[31:26];
   assign rt  = ir_ff[25:21];
   assign ra  = ir_ff[20:16];
   assign rb  = ir_ff[15:11];
   assign mb  = ir_ff[10:6];
   assign me  = ir_ff[5:1];
   assign x9  = ir_ff[9:1];
   assign x10 = ir_ff[10:1];
   assign d   = {{16{ir_ff[15]}}, ir_ff[15:0]};
   assign base = (ra == 5'd0) ? 32'd0 : ra_ff;
   assign seq = pc_ff + ADDR_W'(4);
   assign seq32 = 32'(seq);
   assign crv = cr_ff[ra[4:2]];
   assign cmpb = (op == OP_CMPI) ? d : rb_ff;
   assign cmpres = ($signed(ra_ff) < $signed(cmpb)) ? CR_LT :
                   ($signed(ra_ff) > $signed(cmpb)) ? CR_GT : CR_EQ;
   assign rot = (rs_ff << rb) | (rs_ff >> ((6'd32 - {1'b0, rb}) & 6'd31));
   assign m1 = 32'hFFFF_FFFF >> mb;
   assign m2 = 32'hFFFF_FFFF << (5'd31 - me);
   assign mask = (mb <= me) ? (m1 & m2) : (m1 | m2);
   assign is_mem = (op == OP_LWZ) || (op == OP_STW) || (op == OP_STWU) ||
                   (op == OP_LMW) || (op == OP_STMW);

   assign stat.is_mem = is_mem;
   assign stat.mem_last = (mbyte_ff == 2'd3) &&
      (((op == OP_LMW) || (op == OP_STMW)) ? (mreg_ff == 5'd31) : 1'b1);

   // Decode of register (non-memory) instructions.
   always_comb begin
      wr_en = 1'b0; wr_idx = rt; wr_val = '0;
      lr_we = 1'b0; lr_val = '0; cr_we = 1'b0;
      halt_in = 1'b0; npc_in = seq; taken = 1'b0; bo_ok = 1'b1;
      case (op)
         OP_X: begin
            if (x9 == X9_ADD) begin
               wr_en = 1'b1; wr_val = ra_ff + rb_ff;
            end else if (x9 == X9_SUBF) begin
               wr_en = 1'b1; wr_val = rb_ff - ra_ff;
            end else if (x10 == X10_MFLR) begin
               wr_en = 1'b1; wr_val = lr_ff;
            end else if (x10 == X10_MTLR) begin
               lr_we = 1'b1; lr_val = rs_ff;
            end else if (x10 == X10_MR) begin
               wr_en = 1'b1; wr_idx = ra; wr_val = rs_ff;
            end else if (x10 == X10_CMP) begin
               cr_we = 1'b1;
            end else if (x10 == X10_SLW) begin
               wr_en = 1'b1; wr_idx = ra;
               wr_val = rb_ff[5] ? 32'd0 : (rs_ff << rb_ff[4:0]);
            end else begin
               halt_in = 1'b1;
            end
         end
         OP_CMPI: cr_we = 1'b1;
         OP_BC: begin
            if (ir_ff[1:0] != 2'b00) begin
               halt_in = 1'b1;
            end else begin
               if (rt == BO_NE) taken = (crv != CR_EQ);
               else if (rt == BO_GT) taken = (crv == CR_GT);
               else if (rt == BO_LT) taken = (crv == CR_LT);
               else bo_ok = 1'b0;
               halt_in = ~bo_ok;
               if (taken) npc_in = pc_ff + ADDR_W'({{18{ir_ff[15]}}, ir_ff[15:2], 2'b00});
            end
         end
         OP_ADDI: begin
            wr_en = 1'b1; wr_val = base + d;
         end
         OP_OUT: ;
         OP_XL: begin
            if (x10 == X10_BLR) begin
               if (lr_ff != 32'hFFFF_FFFF) npc_in = lr_ff[ADDR_W-1:0];
            end else begin
               halt_in = 1'b1;
            end
         end
         OP_B: begin
            if (ir_ff[0]) begin
               lr_we = 1'b1; lr_val = seq32;
            end
            npc_in = pc_ff + ADDR_W'({{8{ir_ff[25]}}, ir_ff[25:2], 2'b00});
         end
         OP_RLWNM: begin
            wr_en = 1'b1; wr_idx = ra; wr_val = rot & mask;
         end
         OP_LWZ, OP_STW, OP_STWU, OP_LMW, OP_STMW: ;
         default: halt_in = 1'b1;
      endcase
      if (halt_in) npc_in = pc_ff;
   end

   // Memory word transfer, one byte per start/writeback pair, big-endian.
   logic [ADDR_W-1:0] baddr;
   logic is_store;
   assign baddr = ea_ff[ADDR_W-1:0] + ADDR_W'(mbyte_ff);
   assign is_store = (op == OP_STW) || (op == OP_STWU) || (op == OP_STMW);

   always_ff @(posedge clock) begin
      if (cmd.mem_start) begin
         if (is_store) mem[baddr] <= mword_ff[31:24];
         mrd_ff <= mem[baddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_instr) begin
         ir_ff <= req_instr;
      end
      // Register read in the cycle after capture.
      rs_ff <= gpr_ff[rt];
      ra_ff <= gpr_ff[ra];
      rb_ff <= gpr_ff[rb];
      if (cmd.finish) begin
         rsp_pc_ff <= 16'(npc_in);
         rsp_ov_ff <= (op == OP_OUT);
         rsp_ch_ff <= (op == OP_OUT) ? rs_ff[7:0] : 8'd0;
         rsp_h_ff  <= halt_in;
      end
   end

   // Memory walk bookkeeping; first word set up during execute.
   logic mem_first;
   assign mem_first = !cmd.exec && !cmd.mem_start && !cmd.mem_wb;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) begin
            gpr_ff[i] <= (i == 1) ? 32'd2000 : (i == 3) ? 32'd5000 : 32'd0;
         end
         for (int i = 0; i < 8; i++) cr_ff[i] <= '0;
         lr_ff <= 32'hFFFF_FFFF;
         pc_ff <= '0;
         mbyte_ff <= '0;
         mreg_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_STACK) gpr_ff[1] <= csr_data;
            else gpr_ff[3] <= csr_data;
         end
         if (cmd.exec) begin
            if (wr_en) gpr_ff[wr_idx] <= wr_val;
            if (lr_we) lr_ff <= lr_val;
            if (cr_we) cr_ff[ir_ff[25:23]] <= cmpres;
         end
         if (mem_first && is_mem) begin
            // Prepare first word after register read.
            ea_ff <= ((op == OP_STWU) ? ra_ff : base) + d;
            mreg_ff <= rt;
            mbyte_ff <= '0;
            mword_ff <= rs_ff;
         end
         if (cmd.mem_wb) begin
            mbyte_ff <= mbyte_ff + 2'd1;
            if ((op == OP_STMW) && (mbyte_ff == 2'd3)) mword_ff <= gpr_ff[mreg_ff + 5'd1];
            else if (is_store) mword_ff <= {mword_ff[23:0], 8'd0};
            else mword_ff <= {mword_ff[23:0], mrd_ff};
            if (mbyte_ff == 2'd3) begin
               if (!is_store) gpr_ff[mreg_ff] <= {mword_ff[23:0], mrd_ff};
               if (op == OP_STWU) gpr_ff[ra] <= ea_ff;
               ea_ff <= ea_ff + 32'd4;
               mreg_ff <= mreg_ff + 5'd1;
            end
         end
         if (cmd.finish) pc_ff <= npc_in;
      end
   end

   assign rsp_next_pc   = rsp_pc_ff;
   assign rsp_out_valid = rsp_ov_ff;
   assign rsp_out_char  = rsp_ch_ff;
   assign rsp_halted    = rsp_h_ff;

`ifndef NO_ASSERTIONS
   a_pc_on_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_next_pc == 16'(pc_ff)) else $error("pc and response differ");
   a_halt_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && halt_in |=> $stable(pc_ff)) else $error("halt moved pc");
   a_byte_walk: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wb |-> $past(cmd.mem_start)) else $error("writeback without start");
`endif
endmodule

// ----- rtl/powerpc_subset_instruction_executor_core.sv -----
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_instr
// rsp       out        rsp_valid, rsp_ready, rsp_next_pc, rsp_out_valid, rsp_out_char, rsp_halted
// csr       in         csr_write, csr_index, csr_data
// A register instruction passes through the read and execute states and raises rsp_valid in
// the response state; the next request is taken after the return to idle.
// Memory instructions move each word a byte at a time through the memory and writeback states
// (one byte memory port); lmw/stmw move 32 minus rt words. Synchronous reset; no memory clear.
// One request is in flight; a stalled response holds the next request off.
// Depends on ppc_pkg, ppc_ctrl and ppc_dpath.
module powerpc_subset_instruction_executor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_next_pc,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_halted,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   import ppc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ppc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   ppc_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .req_instr(req_instr),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_next_pc(rsp_next_pc), .rsp_out_valid(rsp_out_valid),
      .rsp_out_char(rsp_out_char), .rsp_halted(rsp_halted)
   );
endmodule
